@@ rtl/fmts_pkg.sv @@
// Shared types, constants and helper functions for the FM chip timer and status unit.
// Has no dependencies; every other file of the unit but fmts_checker imports it.
`timescale 1ns / 1ps
`default_nettype none

package fmts_pkg;

    // Time and timer geometry.
    localparam int TIME_BITS   = 32;
    localparam int T1_UNIT_US  = 80;
    localparam int T2_UNIT_US  = 320;
    localparam int T1_PER_W    = 15;
    localparam int T2_PER_W    = 17;
    localparam int PER_W       = T2_PER_W;

    // The remainder unit retires two dividend bits per cycle.
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = TIME_BITS / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    localparam logic [T1_PER_W-1:0] T1_PER_RST = T1_PER_W'(T1_UNIT_US * 256);
    localparam logic [T2_PER_W-1:0] T2_PER_RST = T2_PER_W'(T2_UNIT_US * 256);

    // Register indexes that the timer logic owns.
    localparam logic [7:0] REG_TIMER1     = 8'h02;
    localparam logic [7:0] REG_TIMER2     = 8'h03;
    localparam logic [7:0] REG_TIMER_CTRL = 8'h04;

    // Bit positions in the timer control byte.
    localparam int CTRL_CLEAR_BIT = 7;
    localparam int CTRL_MASK1_BIT = 6;
    localparam int CTRL_MASK2_BIT = 5;
    localparam int CTRL_EN1_BIT   = 0;
    localparam int CTRL_EN2_BIT   = 1;

    // Bit positions in the status byte.
    localparam int STS_IRQ_BIT = 7;
    localparam int STS_T1_BIT  = 6;
    localparam int STS_T2_BIT  = 5;

    typedef enum logic [1:0] {
        CMD_RESET       = 2'd0,
        CMD_ADDR_WRITE  = 2'd1,
        CMD_DATA_WRITE  = 2'd2,
        CMD_STATUS_READ = 2'd3
    } t_cmd;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // capture the incoming request
        logic div_load;     // start a remainder for the selected timer
        logic div_step;     // retire two dividend bits
        logic apply_check;  // rebase the selected timer and raise its flag
        logic commit;       // apply the request and load the result register
        logic tsel;         // 0 selects timer 1, 1 selects timer 2
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic expired;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [T1_PER_W-1:0] t1_period_of(input logic [7:0] d);
        logic [8:0] ticks;
        ticks = 9'd256 - {1'b0, d};
        return T1_PER_W'(T1_UNIT_US * ticks);
    endfunction

    function automatic logic [T2_PER_W-1:0] t2_period_of(input logic [7:0] d);
        logic [8:0] ticks;
        ticks = 9'd256 - {1'b0, d};
        return T2_PER_W'(T2_UNIT_US * ticks);
    endfunction

endpackage

`default_nettype wire

@@ rtl/fmts_ifs.sv @@
// Request and response channel interfaces of the FM chip timer and status unit.
// Depends on fmts_pkg for the time width.
`timescale 1ns / 1ps
`default_nettype none

interface fmts_req_if import fmts_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic [7:0]           data_byte;
    logic [TIME_BITS-1:0] now_us;

    modport source (output valid, command, data_byte, now_us, input ready);
    modport sink   (input valid, command, data_byte, now_us, output ready);
endinterface

interface fmts_rsp_if ();
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic       forward_valid;
    logic [7:0] forward_register;
    logic [7:0] forward_data;

    modport source (output valid, status_byte, forward_valid, forward_register, forward_data,
                    input ready);
    modport sink   (input valid, status_byte, forward_valid, forward_register, forward_data,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/fmts_datapath.sv @@
// Datapath of the timer and status unit: timer state, remainder unit and result register.
// Depends on fmts_pkg; driven by fmts_controller through t_dp_cmd.
`timescale 1ns / 1ps
`default_nettype none

module fmts_datapath
    import fmts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_data_byte,
    input  logic [TIME_BITS-1:0] i_now_us,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [7:0]           o_status_byte,
    output logic                 o_forward_valid,
    output logic [7:0]           o_forward_register,
    output logic [7:0]           o_forward_data
);

    // Captured request.
    t_cmd                 r_cmd;
    logic [7:0]           r_data;
    logic [TIME_BITS-1:0] r_now;

    // Architectural state.
    logic [7:0]           r_sel_reg;
    logic                 r_irq;
    logic                 r_t1_exp, r_t2_exp;
    logic                 r_t1_en, r_t2_en;
    logic                 r_t1_mask, r_t2_mask;
    logic [T1_PER_W-1:0]  r_t1_per;
    logic [T2_PER_W-1:0]  r_t2_per;
    logic [TIME_BITS-1:0] r_t1_base, r_t2_base;

    // Remainder unit.
    logic [TIME_BITS-1:0] r_dvd;
    logic [PER_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;

    // Result register.
    logic                 r_out_valid;
    logic [7:0]           r_out_status;
    logic                 r_out_fwd_valid;
    logic [7:0]           r_out_fwd_reg;
    logic [7:0]           r_out_fwd_data;

    logic [TIME_BITS-1:0] w_base_sel;
    logic [PER_W-1:0]     w_per_sel;
    logic                 w_en_sel;
    logic [TIME_BITS-1:0] w_diff;
    logic                 w_late;
    logic [PER_W:0]       w_try0, w_try1;
    logic [PER_W-1:0]     w_rem_mid;
    logic [PER_W-1:0]     n_rem;
    logic [TIME_BITS-1:0] n_base;
    logic                 w_fwd;
    logic [7:0]           n_status;

    assign w_base_sel = i_cmd.tsel ? r_t2_base : r_t1_base;
    assign w_per_sel  = i_cmd.tsel ? r_t2_per : PER_W'(r_t1_per);
    assign w_en_sel   = i_cmd.tsel ? r_t2_en : r_t1_en;

    // An enabled timer has expired when time ran backward past its base or beyond one period.
    assign w_diff = r_now - w_base_sel;
    assign w_late = (r_now < w_base_sel) ||
                    (w_diff > {{(TIME_BITS-PER_W){1'b0}}, w_per_sel});

    // Two restoring steps per cycle; the partial remainder always stays below the period.
    assign w_try0    = {r_rem, r_dvd[TIME_BITS-1]};
    assign w_rem_mid = (w_try0 >= {1'b0, w_per_sel}) ?
                       PER_W'(w_try0 - {1'b0, w_per_sel}) : w_try0[PER_W-1:0];
    assign w_try1    = {w_rem_mid, r_dvd[TIME_BITS-2]};
    assign n_rem     = (w_try1 >= {1'b0, w_per_sel}) ?
                       PER_W'(w_try1 - {1'b0, w_per_sel}) : w_try1[PER_W-1:0];

    // The base moves back to the most recent rollover.
    assign n_base = r_now - {{(TIME_BITS-PER_W){1'b0}}, r_rem};

    assign w_fwd = (r_cmd == CMD_DATA_WRITE) &&
                   !(r_sel_reg inside {REG_TIMER1, REG_TIMER2, REG_TIMER_CTRL});

    always_comb begin
        n_status = 8'h00;
        if (r_cmd == CMD_STATUS_READ) begin
            n_status[STS_IRQ_BIT] = r_t1_exp | r_t2_exp;
            n_status[STS_T1_BIT]  = r_t1_exp;
            n_status[STS_T2_BIT]  = r_t2_exp;
        end
    end

    assign o_sts.is_read  = (r_cmd == CMD_STATUS_READ);
    assign o_sts.expired  = w_en_sel && w_late;
    assign o_sts.div_last = (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Request capture and remainder unit; payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= t_cmd'(i_command);
            r_data <= i_data_byte;
            r_now  <= i_now_us;
        end
        if (i_cmd.div_load) begin
            r_dvd <= w_diff;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << DIV_BITS_PER_CYCLE;
            r_rem <= n_rem;
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    // Timer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_reg <= 8'h00;
            r_irq     <= 1'b0;
            r_t1_exp  <= 1'b0;
            r_t2_exp  <= 1'b0;
            r_t1_en   <= 1'b1;
            r_t2_en   <= 1'b1;
            r_t1_mask <= 1'b0;
            r_t2_mask <= 1'b0;
            r_t1_per  <= T1_PER_RST;
            r_t2_per  <= T2_PER_RST;
            r_t1_base <= '0;
            r_t2_base <= '0;
        end else begin
            if (i_cmd.apply_check) begin
                if (i_cmd.tsel) begin
                    r_t2_base <= n_base;
                    if (!r_t2_mask) r_t2_exp <= 1'b1;
                end else begin
                    r_t1_base <= n_base;
                    if (!r_t1_mask) r_t1_exp <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                case (r_cmd)
                    CMD_RESET: begin
                        r_irq     <= 1'b0;
                        r_t1_exp  <= 1'b0;
                        r_t2_exp  <= 1'b0;
                        r_t1_en   <= 1'b1;
                        r_t2_en   <= 1'b1;
                        r_t1_mask <= 1'b0;
                        r_t2_mask <= 1'b0;
                        r_t1_per  <= T1_PER_RST;
                        r_t2_per  <= T2_PER_RST;
                        r_t1_base <= r_now;
                        r_t2_base <= r_now;
                    end
                    CMD_ADDR_WRITE: begin
                        r_sel_reg <= r_data;
                    end
                    CMD_DATA_WRITE: begin
                        case (r_sel_reg)
                            REG_TIMER1: begin
                                r_t1_per <= t1_period_of(r_data);
                            end
                            REG_TIMER2: begin
                                r_t2_per <= t2_period_of(r_data);
                            end
                            REG_TIMER_CTRL: begin
                                if (r_data[CTRL_CLEAR_BIT]) begin
                                    r_irq    <= 1'b0;
                                    r_t1_exp <= 1'b0;
                                    r_t2_exp <= 1'b0;
                                end else begin
                                    r_t1_mask <= r_data[CTRL_MASK1_BIT];
                                    r_t2_mask <= r_data[CTRL_MASK2_BIT];
                                    if (r_data[CTRL_MASK1_BIT]) r_t1_exp <= 1'b0;
                                    if (r_data[CTRL_MASK2_BIT]) r_t2_exp <= 1'b0;
                                    if (r_data[CTRL_EN1_BIT] && !r_t1_en) r_t1_base <= r_now;
                                    if (r_data[CTRL_EN2_BIT] && !r_t2_en) r_t2_base <= r_now;
                                    r_t1_en <= r_data[CTRL_EN1_BIT];
                                    r_t2_en <= r_data[CTRL_EN2_BIT];
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    CMD_STATUS_READ: begin
                        r_irq <= r_t1_exp | r_t2_exp;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status    <= n_status;
            r_out_fwd_valid <= w_fwd;
            r_out_fwd_reg   <= w_fwd ? r_sel_reg : 8'h00;
            r_out_fwd_data  <= w_fwd ? r_data : 8'h00;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status_byte      = r_out_status;
    assign o_forward_valid    = r_out_fwd_valid;
    assign o_forward_register = r_out_fwd_reg;
    assign o_forward_data     = r_out_fwd_data;

endmodule

`default_nettype wire

@@ rtl/fmts_controller.sv @@
// Sequencing state machine of the timer and status unit.
// Depends on fmts_pkg; drives fmts_datapath through t_dp_cmd and reads t_dp_sts back.
`timescale 1ns / 1ps
`default_nettype none

module fmts_controller
    import fmts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DISP = 6'b000010,
        S_CHK  = 6'b000100,
        S_DIV  = 6'b001000,
        S_UPD  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_tsel, n_tsel;

    always_comb begin
        n_state    = r_state;
        n_tsel     = r_tsel;
        o_cmd      = '0;
        o_cmd.tsel = r_tsel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                n_tsel  = 1'b0;
                n_state = i_sts.is_read ? S_CHK : S_FIN;
            end
            S_CHK: begin
                // An expired timer needs its remainder; otherwise move on.
                if (i_sts.expired) begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                end else if (!r_tsel) begin
                    n_tsel = 1'b1;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.apply_check = 1'b1;
                if (!r_tsel) begin
                    n_tsel  = 1'b1;
                    n_state = S_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tsel  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tsel  <= n_tsel;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

@@ rtl/fm_chip_timer_status_unit.sv @@
// Top level of the FM chip timer and status unit: controller plus datapath.
// Depends on fmts_pkg, fmts_ifs, fmts_controller and fmts_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The unit models the timer and status side of a YM3812-style FM chip. Each request on
// i_req is one bus access (reset, address write, data write or status read) carrying a
// data byte and the current 32-bit microsecond time, and each produces exactly one
// response on o_rsp. Data writes to registers 2 and 3 load the timer periods, register 4
// controls masks, enables and flag clearing, and any other data write is forwarded on
// the response for the synthesizer. A reset or write passes from the idle state through
// the dispatch state to the final state, where the response register loads as soon as
// it is free. A status read checks timer 1 and then timer 2 before the final state:
// each enabled timer that has expired runs through the shared remainder unit, which
// retires two bits of the 32-bit elapsed time per cycle, and is then rebased. One
// request is handled at a time; a new request is accepted once the previous one has
// been placed in the response register, even while that response still waits for
// the sink.

module fm_chip_timer_status_unit
    import fmts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    fmts_req_if.sink   i_req,
    fmts_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller sequences the timer checks and decides when a request commits.
    fmts_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds all timer state, the remainder unit and the response register.
    fmts_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_command          (i_req.command),
        .i_data_byte        (i_req.data_byte),
        .i_now_us           (i_req.now_us),
        .i_out_ready        (o_rsp.ready),
        .o_out_valid        (o_rsp.valid),
        .o_status_byte      (o_rsp.status_byte),
        .o_forward_valid    (o_rsp.forward_valid),
        .o_forward_register (o_rsp.forward_register),
        .o_forward_data     (o_rsp.forward_data)
    );

endmodule

`default_nettype wire

@@ rtl/fmts_checker.sv @@
// Port-level checks for the timer and status unit, bound to its top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module fmts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [7:0] i_status_byte,
    input logic       i_forward_valid,
    input logic [7:0] i_forward_register,
    input logic [7:0] i_forward_data
);

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another was in work");

    // A stalled response stays valid and unchanged until the sink takes it.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_status_byte) && $stable(i_forward_valid) &&
             $stable(i_forward_register) && $stable(i_forward_data)))
        else $error("stalled response changed or was dropped");

    // A forwarded write never carries status.
    a_fwd_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_forward_valid) |-> (i_status_byte == 8'h00))
        else $error("forwarded write carries status bits");

    // Forward fields are zero unless a write is forwarded.
    a_fwd_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_forward_valid) |->
            (i_forward_register == 8'h00 && i_forward_data == 8'h00))
        else $error("forward fields set without a forwarded write");

    // The IRQ bit is the OR of the timer flags, and the low bits stay clear.
    a_irq_is_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status_byte[7] == (i_status_byte[6] | i_status_byte[5]) &&
                         i_status_byte[4:0] == 5'd0))
        else $error("status byte is inconsistent");

endmodule

bind fm_chip_timer_status_unit fmts_checker u_fmts_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_status_byte      (o_rsp.status_byte),
    .i_forward_valid    (o_rsp.forward_valid),
    .i_forward_register (o_rsp.forward_register),
    .i_forward_data     (o_rsp.forward_data)
);

`default_nettype wire
